// ===== hw/rtl/rfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants of the clipped rectangle fill stream unit.
// ----------------------------------------------------------------------------
package rfs_pkg;

    // Display command bytes.
    localparam logic [7:0] CMD_COL_WINDOW = 8'h2A;
    localparam logic [7:0] CMD_ROW_WINDOW = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

    // Configuration register indexes.
    localparam logic [1:0] REG_PANEL_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROW_OFFSET  = 2'd1;
    localparam logic [1:0] REG_LAST_ROW    = 2'd2;

    // Input item kinds.
    localparam logic REQ_RECT    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Sequence steps: header bytes, then the pixel phase.
    localparam logic [3:0] STEP_COL_CMD    = 4'd0;
    localparam logic [3:0] STEP_COL_START_H = 4'd1;
    localparam logic [3:0] STEP_COL_START_L = 4'd2;
    localparam logic [3:0] STEP_COL_END_H  = 4'd3;
    localparam logic [3:0] STEP_COL_END_L  = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD    = 4'd5;
    localparam logic [3:0] STEP_ROW_START_H = 4'd6;
    localparam logic [3:0] STEP_ROW_START_L = 4'd7;
    localparam logic [3:0] STEP_ROW_END_H  = 4'd8;
    localparam logic [3:0] STEP_ROW_END_L  = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD    = 4'd10;
    localparam logic [3:0] STEP_PIXELS     = 4'd11;

    // Result of clipping one rectangle request against the panel.
    typedef struct packed {
        logic        keep;
        logic [10:0] col_start;
        logic [10:0] col_end;
        logic [9:0]  row_start;
        logic [9:0]  row_end;
        logic [10:0] width;
        logic [10:0] height;
    } clip_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rfs_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_clip
// Clips a rectangle request against the panel and decides whether it is drawn.
// ----------------------------------------------------------------------------
module rfs_clip #(
    parameter int PANEL_MAX = 1024
) (
    input  wire logic [15:0] rect_x,
    input  wire logic [15:0] rect_y,
    input  wire logic [15:0] rect_w,
    input  wire logic [15:0] rect_h,
    input  wire logic [10:0] panel_width,
    input  wire logic [9:0]  row_offset,
    input  wire logic [9:0]  last_row,
    output rfs_pkg::clip_t   clip
);

    localparam logic [31:0] PMAX = 32'(PANEL_MAX);

    logic [10:0] pw_eff;
    logic        x_in;
    logic [10:0] w_room;
    logic [10:0] w_clip;
    logic [16:0] sy;
    logic        y_in;
    logic [10:0] h_room;
    logic [10:0] h_clip;
    logic [10:0] row_end_wide;

    always_comb begin
        // A panel width above the supported maximum is taken as the maximum.
        pw_eff = (32'(panel_width) > PMAX) ? PMAX[10:0] : panel_width;

        x_in   = rect_x < {5'd0, pw_eff};
        w_room = pw_eff - rect_x[10:0];
        w_clip = ({5'd0, w_room} < rect_w) ? w_room : rect_w[10:0];

        sy     = {1'b0, rect_y} + 17'(row_offset);
        y_in   = sy <= 17'(last_row);
        h_room = 11'(last_row) - 11'(sy[9:0]) + 11'd1;
        h_clip = ({5'd0, h_room} < rect_h) ? h_room : rect_h[10:0];
        row_end_wide = 11'(sy[9:0]) + h_clip - 11'd1;

        clip.keep      = x_in && (rect_w != 16'd0) && y_in && (rect_h != 16'd0);
        clip.col_start = rect_x[10:0];
        clip.col_end   = rect_x[10:0] + w_clip - 11'd1;
        clip.row_start = sy[9:0];
        clip.row_end   = row_end_wide[9:0];
        clip.width     = w_clip;
        clip.height    = h_clip;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/clipped_rectangle_fill_stream_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_rectangle_fill_stream_unit
// Turns rectangle fill requests into the display byte stream that sets the
// column and row window and then writes the fill color into every pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_tvalid/s_tready    request or advance item
//  m_        out        m_tvalid/m_tready    one display byte per advance
//  cfg_      in         cfg_valid/cfg_ready  panel_width, row_offset, last_row
//
// An accepted advance item places its byte in the output register at the next
// clock edge, and a new item can be taken in every cycle that s_tready is
// high. The pixel count multiply runs from registered extents while the
// header bytes go out, so it never sits on the request path.
// Reset is synchronous and active low; it returns the block to idle with the
// default panel geometry. s_tready is low only while the output register holds
// an item that the sink is not taking in this cycle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module clipped_rectangle_fill_stream_unit #(
    parameter int PANEL_MAX = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: rect_x[15:0], rect_y[15:0], rect_w[15:0],
    // rect_h[15:0], fill_color[15:0]
    input  wire logic [79:0] s_tdata,
    // s_tuser: req_type (0 rectangle request, 1 advance)
    input  wire logic        s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: out_byte[7:0]
    output logic [7:0]       m_tdata,
    // m_tuser, from bit 0: is_data, frame_end
    output logic [1:0]       m_tuser,
    output logic             m_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    // Configuration registers.
    logic [10:0] panel_width_reg;
    logic [9:0]  row_offset_reg;
    logic [9:0]  last_row_reg;

    // Transfer state.
    logic        busy_reg,       busy_next;
    logic [3:0]  step_reg,       step_next;
    logic        low_half_reg,   low_half_next;
    logic [20:0] pixels_left_reg, pixels_left_next;
    logic [10:0] col_start_reg,  col_start_next;
    logic [10:0] col_end_reg,    col_end_next;
    logic [9:0]  row_start_reg,  row_start_next;
    logic [9:0]  row_end_reg,    row_end_next;
    logic [10:0] width_reg,      width_next;
    logic [10:0] height_reg,     height_next;
    logic [15:0] color_reg,      color_next;

    // Output register.
    logic        m_valid_reg,    m_valid_next;
    logic [7:0]  m_byte_reg,     m_byte_next;
    logic        m_is_data_reg,  m_is_data_next;
    logic        m_frame_end_reg, m_frame_end_next;
    logic        m_last_reg,     m_last_next;

    logic           s_accept;
    logic [20:0]    pixels_dec;
    rfs_pkg::clip_t clip;

    rfs_clip #(
        .PANEL_MAX (PANEL_MAX)
    ) u_clip (
        .rect_x      (s_tdata[15:0]),
        .rect_y      (s_tdata[31:16]),
        .rect_w      (s_tdata[47:32]),
        .rect_h      (s_tdata[63:48]),
        .panel_width (panel_width_reg),
        .row_offset  (row_offset_reg),
        .last_row    (last_row_reg),
        .clip        (clip)
    );

    // The output register frees up in the same cycle the sink takes its item.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_frame_end_reg, m_is_data_reg};
    assign m_tlast  = m_last_reg;

    // Pixel count after this low byte; a count that is already zero stays zero.
    assign pixels_dec = pixels_left_reg - ((pixels_left_reg != 21'd0) ? 21'd1 : 21'd0);

    always_comb begin
        busy_next        = busy_reg;
        step_next        = step_reg;
        low_half_next    = low_half_reg;
        pixels_left_next = pixels_left_reg;
        col_start_next   = col_start_reg;
        col_end_next     = col_end_reg;
        row_start_next   = row_start_reg;
        row_end_next     = row_end_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        color_next       = color_reg;

        m_valid_next     = m_valid_reg && !m_tready;
        m_byte_next      = m_byte_reg;
        m_is_data_next   = m_is_data_reg;
        m_frame_end_next = m_frame_end_reg;
        m_last_next      = m_last_reg;

        // While the header goes out, the pixel count is formed from the
        // clipped extents; it is first needed in the pixel phase.
        if (busy_reg && (step_reg < rfs_pkg::STEP_PIXELS)) begin
            pixels_left_next = 21'({11'd0, width_reg} * {11'd0, height_reg});
        end

        if (s_accept && (s_tuser == rfs_pkg::REQ_RECT)) begin
            // Requests that arrive during a transfer are ignored.
            if (!busy_reg && clip.keep) begin
                busy_next      = 1'b1;
                step_next      = rfs_pkg::STEP_COL_CMD;
                low_half_next  = 1'b0;
                col_start_next = clip.col_start;
                col_end_next   = clip.col_end;
                row_start_next = clip.row_start;
                row_end_next   = clip.row_end;
                width_next     = clip.width;
                height_next    = clip.height;
                color_next     = s_tdata[79:64];
            end
        end else if (s_accept && busy_reg) begin
            m_valid_next     = 1'b1;
            m_is_data_next   = 1'b1;
            m_frame_end_next = 1'b1;
            m_last_next      = 1'b0;
            step_next        = step_reg + 4'd1;
            unique case (step_reg)
                rfs_pkg::STEP_COL_CMD: begin
                    m_byte_next    = rfs_pkg::CMD_COL_WINDOW;
                    m_is_data_next = 1'b0;
                end
                rfs_pkg::STEP_COL_START_H: m_byte_next = {5'd0, col_start_reg[10:8]};
                rfs_pkg::STEP_COL_START_L: m_byte_next = col_start_reg[7:0];
                rfs_pkg::STEP_COL_END_H:   m_byte_next = {5'd0, col_end_reg[10:8]};
                rfs_pkg::STEP_COL_END_L:   m_byte_next = col_end_reg[7:0];
                rfs_pkg::STEP_ROW_CMD: begin
                    m_byte_next    = rfs_pkg::CMD_ROW_WINDOW;
                    m_is_data_next = 1'b0;
                end
                rfs_pkg::STEP_ROW_START_H: m_byte_next = {6'd0, row_start_reg[9:8]};
                rfs_pkg::STEP_ROW_START_L: m_byte_next = row_start_reg[7:0];
                rfs_pkg::STEP_ROW_END_H:   m_byte_next = {6'd0, row_end_reg[9:8]};
                rfs_pkg::STEP_ROW_END_L:   m_byte_next = row_end_reg[7:0];
                rfs_pkg::STEP_MEM_CMD: begin
                    m_byte_next    = rfs_pkg::CMD_MEM_WRITE;
                    m_is_data_next = 1'b0;
                end
                default: begin
                    // Pixel phase: all pixel bytes share one chip-select frame.
                    step_next = step_reg;
                    if (!low_half_reg) begin
                        m_byte_next      = color_reg[15:8];
                        m_frame_end_next = 1'b0;
                        low_half_next    = 1'b1;
                    end else begin
                        m_byte_next      = color_reg[7:0];
                        low_half_next    = 1'b0;
                        pixels_left_next = pixels_dec;
                        if (pixels_dec == 21'd0) begin
                            m_last_next = 1'b1;
                            busy_next   = 1'b0;
                            step_next   = rfs_pkg::STEP_COL_CMD;
                        end else begin
                            m_frame_end_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_width_reg <= 11'd320;
            row_offset_reg  <= 10'd0;
            last_row_reg    <= 10'd239;
            busy_reg        <= 1'b0;
            step_reg        <= rfs_pkg::STEP_COL_CMD;
            low_half_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    rfs_pkg::REG_PANEL_WIDTH: panel_width_reg <= cfg_data;
                    rfs_pkg::REG_ROW_OFFSET:  row_offset_reg  <= cfg_data[9:0];
                    rfs_pkg::REG_LAST_ROW:    last_row_reg    <= cfg_data[9:0];
                    default: ;
                endcase
            end
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            low_half_reg <= low_half_next;
            m_valid_reg  <= m_valid_next;
        end
        pixels_left_reg <= pixels_left_next;
        col_start_reg   <= col_start_next;
        col_end_reg     <= col_end_next;
        row_start_reg   <= row_start_next;
        row_end_reg     <= row_end_next;
        width_reg       <= width_next;
        height_reg      <= height_next;
        color_reg       <= color_next;
        m_byte_reg      <= m_byte_next;
        m_is_data_reg   <= m_is_data_next;
        m_frame_end_reg <= m_frame_end_next;
        m_last_reg      <= m_last_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_checker
// Port-level checks of the clipped rectangle fill stream unit.
// ----------------------------------------------------------------------------
module rfs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled output item holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // With an empty output register the block always takes input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input refused while output register empty");

    // The final byte of a transfer is a data byte that closes its frame.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[1])
        else $error("final byte is not a data byte closing the frame");

    // Command bytes travel in a frame of their own and never end a transfer.
    a_cmd_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1] && !m_tlast)
        else $error("command byte not in its own frame");

endmodule

bind clipped_rectangle_fill_stream_unit rfs_checker u_rfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped rectangle fill stream unit. A scoreboard
// tracks panel geometry and transfer state, predicts every display byte from
// the accepted items, and compares each byte that leaves the block in order.
// ----------------------------------------------------------------------------
module tb_top;

    // Effective column limit of the instance (default PANEL_MAX).
    localparam int unsigned PANEL_LIMIT = 1024;
    // Generous bound on the whole run in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Cycles to let pass after the last byte before touching the registers.
    localparam int unsigned SETTLE_CYCLES = 4;

    // One display byte as it appears on the result channel.
    typedef struct {
        logic [7:0] value;
        logic       is_data;
        logic       frame_end;
        logic       last;
    } display_byte_t;

    // Tracks geometry and transfer progress, predicts display bytes and
    // checks the bytes that the block delivers.
    class fill_scoreboard;
        int unsigned   panel_width;
        int unsigned   row_offset;
        int unsigned   last_row;
        bit            busy;
        logic [15:0]   col_start;
        logic [15:0]   col_end;
        logic [15:0]   row_start;
        logic [15:0]   row_end;
        logic [15:0]   color_hold;
        logic [3:0]    step;
        logic [20:0]   pixels_left;
        bit            low_next;
        display_byte_t bytes_due[$];
        int unsigned   errors;
        int unsigned   bytes_checked;
        int unsigned   rects_drawn;
        int unsigned   rects_dropped;
        int unsigned   rects_ignored;

        function new();
            panel_width = 320;
            row_offset  = 0;
            last_row    = 239;
            busy        = 1'b0;
            col_start   = '0;
            col_end     = '0;
            row_start   = '0;
            row_end     = '0;
            color_hold  = '0;
            step        = rfs_pkg::STEP_COL_CMD;
            pixels_left = '0;
            low_next    = 1'b0;
        endfunction

        function int unsigned usable_width();
            return (panel_width > PANEL_LIMIT) ? PANEL_LIMIT : panel_width;
        endfunction

        function void write_reg(logic [1:0] index, logic [10:0] value);
            case (index)
                rfs_pkg::REG_PANEL_WIDTH: panel_width = value;
                rfs_pkg::REG_ROW_OFFSET:  row_offset  = value[9:0];
                rfs_pkg::REG_LAST_ROW:    last_row    = value[9:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] value, logic is_data, logic frame_end,
                                logic last);
            display_byte_t b;
            b.value     = value;
            b.is_data   = is_data;
            b.frame_end = frame_end;
            b.last      = last;
            bytes_due.push_back(b);
        endfunction

        // Clips a request against the panel and arms a transfer if it survives.
        function void clip_request(logic [79:0] data);
            int unsigned x, y, w, h, pw, sy, ey;
            x  = data[15:0];
            y  = data[31:16];
            w  = data[47:32];
            h  = data[63:48];
            pw = usable_width();
            if (x >= pw || w == 0) begin
                rects_dropped++;
                return;
            end
            if (x + w > pw) w = pw - x;
            sy = y + row_offset;
            if (sy > last_row || h == 0) begin
                rects_dropped++;
                return;
            end
            ey = sy + h - 1;
            if (ey > last_row) begin
                ey = last_row;
                h  = ey - sy + 1;
            end
            col_start   = x[15:0];
            col_end     = 16'(x + w - 1);
            row_start   = sy[15:0];
            row_end     = ey[15:0];
            color_hold  = data[79:64];
            pixels_left = 21'(w * h);
            step        = rfs_pkg::STEP_COL_CMD;
            low_next    = 1'b0;
            busy        = 1'b1;
            rects_drawn++;
        endfunction

        // Notes one accepted input item. Returns 0 only for a request that arrives mid-transfer.
        function bit take_item(logic kind, logic [79:0] data);
            bit header;
            if (kind == rfs_pkg::REQ_RECT) begin
                if (busy) begin
                    rects_ignored++;
                    return 1'b0;
                end
                clip_request(data);
                return 1'b1;
            end
            if (!busy) return 1'b1;
            header = 1'b1;
            case (step)
                rfs_pkg::STEP_COL_CMD:
                    push_byte(rfs_pkg::CMD_COL_WINDOW, 1'b0, 1'b1, 1'b0);
                rfs_pkg::STEP_COL_START_H: push_byte(col_start[15:8], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_COL_START_L: push_byte(col_start[7:0], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_COL_END_H:   push_byte(col_end[15:8], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_COL_END_L:   push_byte(col_end[7:0], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_ROW_CMD:
                    push_byte(rfs_pkg::CMD_ROW_WINDOW, 1'b0, 1'b1, 1'b0);
                rfs_pkg::STEP_ROW_START_H: push_byte(row_start[15:8], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_ROW_START_L: push_byte(row_start[7:0], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_ROW_END_H:   push_byte(row_end[15:8], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_ROW_END_L:   push_byte(row_end[7:0], 1'b1, 1'b1, 1'b0);
                rfs_pkg::STEP_MEM_CMD:
                    push_byte(rfs_pkg::CMD_MEM_WRITE, 1'b0, 1'b1, 1'b0);
                default: begin
                    header = 1'b0;
                    if (!low_next) begin
                        push_byte(color_hold[15:8], 1'b1, 1'b0, 1'b0);
                        low_next = 1'b1;
                    end else begin
                        low_next = 1'b0;
                        if (pixels_left > 0) pixels_left = pixels_left - 1;
                        if (pixels_left == 0) begin
                            push_byte(color_hold[7:0], 1'b1, 1'b1, 1'b1);
                            busy = 1'b0;
                            step = rfs_pkg::STEP_COL_CMD;
                        end else begin
                            push_byte(color_hold[7:0], 1'b1, 1'b0, 1'b0);
                        end
                    end
                end
            endcase
            if (header) step = step + 4'd1;
            return 1'b1;
        endfunction

        function void check_byte(logic [7:0] value, logic [1:0] user, logic last);
            display_byte_t want;
            bytes_checked++;
            if (bytes_due.size() == 0) begin
                errors++;
                $error("out_byte %02h arrived while no byte was expected", value);
                return;
            end
            want = bytes_due.pop_front();
            if (value !== want.value) begin
                errors++;
                $error("out_byte: expected %02h, got %02h", want.value, value);
            end
            if (user[0] !== want.is_data) begin
                errors++;
                $error("is_data: expected %0b, got %0b", want.is_data, user[0]);
            end
            if (user[1] !== want.frame_end) begin
                errors++;
                $error("frame_end: expected %0b, got %0b", want.frame_end, user[1]);
            end
            if (last !== want.last) begin
                errors++;
                $error("last: expected %0b, got %0b", want.last, last);
            end
        endfunction
    endclass

    // Clock, reset and block ports. Every input starts at a known value.
    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // s_tdata, from bit 0: rect_x, rect_y, rect_w, rect_h, fill_color
    logic [79:0] s_tdata   = '0;
    // s_tuser: req_type
    logic        s_tuser   = rfs_pkg::REQ_ADVANCE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // m_tdata: out_byte
    logic [7:0]  m_tdata;
    // m_tuser, from bit 0: is_data, frame_end
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = rfs_pkg::REG_PANEL_WIDTH;
    logic [10:0] cfg_data  = '0;

    fill_scoreboard sb = new();

    // When set, neither side inserts idle cycles.
    bit          calm = 1'b0;
    int unsigned useful_items = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;

    clipped_rectangle_fill_stream_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The run must finish well within this many cycles, even with the worst
    // mix of stalls and gaps. Running past it means the block hung or lost
    // a byte that the scoreboard is still waiting for.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Byte sink: checks every byte taken at this edge against the prediction,
    // then decides whether to stall in the next cycle. The values read here
    // are those present at the edge, since everything is driven by NBA.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser, m_tlast);
        m_tready <= calm || ($urandom_range(99, 0) >= 14);
    end

    function automatic logic [79:0] pack_rect(int unsigned x, int unsigned y,
                                              int unsigned w, int unsigned h,
                                              int unsigned color);
        return {color[15:0], h[15:0], w[15:0], y[15:0], x[15:0]};
    endfunction

    // Payload for advance items: the block must ignore it.
    function automatic logic [79:0] noise_word();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[79:0];
    endfunction

    // Presents one item and holds it until the block takes it. The valid
    // line stays high between back-to-back items; a random gap lowers it
    // first, in the step after the previous item was taken.
    task automatic send_item(logic kind, logic [79:0] data);
        if (!calm && $urandom_range(99, 0) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (sb.take_item(kind, data)) useful_items++;
    endtask

    // Pulls the remaining bytes of the transfer under way, if any.
    task automatic drain_transfer();
        while (sb.busy) send_item(rfs_pkg::REQ_ADVANCE, noise_word());
    endtask

    // Stops the input side and waits until every predicted byte has come
    // out, then lets the block settle before any register write.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[10:0];
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(index, value[10:0]);
    endtask

    // Loads a complete panel geometry; only called while the block is idle.
    task automatic apply_panel(int unsigned width, int unsigned offset, int unsigned bottom);
        write_reg(rfs_pkg::REG_PANEL_WIDTH, width);
        write_reg(rfs_pkg::REG_ROW_OFFSET, offset);
        write_reg(rfs_pkg::REG_LAST_ROW, bottom);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random traffic under the current geometry. While a transfer runs most
    // items are advances, with a few stray requests that must be ignored.
    // While idle, if the geometry leaves room, most items are requests that
    // survive clipping, kept small so each transfer stays short; the rest are
    // requests that are sure to be dropped and advances that must produce nothing.
    task automatic run_phase(int unsigned target);
        int unsigned first, pw, ro, lr, rows, cw, ch, x, y, w, h, sy, pick;
        first = useful_items;
        pw    = sb.usable_width();
        ro    = sb.row_offset;
        lr    = sb.last_row;
        while (useful_items - first < target) begin
            pick = $urandom_range(99, 0);
            if (sb.busy) begin
                if (pick < 90) send_item(rfs_pkg::REQ_ADVANCE, noise_word());
                else send_item(rfs_pkg::REQ_RECT, noise_word());
            end else if (pick < 15) begin
                send_item(rfs_pkg::REQ_ADVANCE, noise_word());
            end else if (pick < 85 && pw != 0 && lr >= ro) begin
                // A rectangle that fits, sometimes pushed past the right or
                // bottom edge with an oversized extent so clipping kicks in.
                cw = ($urandom_range(19, 0) == 0) ? 16 : $urandom_range(3, 1);
                if (cw > pw) cw = pw;
                x = $urandom_range(pw - cw, 0);
                w = cw;
                if (x + cw == pw && $urandom_range(1, 0) == 1) w = $urandom_range(65535, cw);
                rows = lr - ro + 1;
                ch = ($urandom_range(19, 0) == 0) ? 16 : $urandom_range(3, 1);
                if (ch > rows) ch = rows;
                sy = $urandom_range(lr - ch + 1, ro);
                y = sy - ro;
                h = ch;
                if (sy + ch - 1 == lr && $urandom_range(1, 0) == 1) h = $urandom_range(65535, ch);
                send_item(rfs_pkg::REQ_RECT, pack_rect(x, y, w, h, $urandom));
            end else begin
                // A request that clipping must reject for one chosen reason.
                x = $urandom_range(65535, 0);
                y = $urandom_range(65535, 0);
                w = $urandom_range(65535, 0);
                h = $urandom_range(65535, 0);
                case ($urandom_range(3, 0))
                    0: x = $urandom_range(65535, pw);
                    1: w = 0;
                    2: h = 0;
                    default: y = $urandom_range(65535, (lr >= ro) ? lr - ro + 1 : 0);
                endcase
                send_item(rfs_pkg::REQ_RECT, pack_rect(x, y, w, h, $urandom));
            end
        end
        drain_transfer();
        settle();
    endtask

    initial begin
        int unsigned ro;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset geometry (320 columns, rows 0..239).
        // An advance with nothing under way must not produce a byte.
        send_item(rfs_pkg::REQ_ADVANCE, '1);
        // Bottom-right corner with maximal extents clips to a single pixel.
        send_item(rfs_pkg::REQ_RECT, pack_rect(319, 239, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // A request arriving mid-transfer is ignored.
        send_item(rfs_pkg::REQ_RECT, pack_rect(0, 0, 5, 5, 16'h1234));
        drain_transfer();
        // Zero width, zero height, off the right edge, below the last row,
        // and everything at its maximum: all dropped.
        send_item(rfs_pkg::REQ_RECT, pack_rect(0, 0, 0, 1, 16'h00FF));
        send_item(rfs_pkg::REQ_RECT, pack_rect(0, 0, 1, 0, 16'hFF00));
        send_item(rfs_pkg::REQ_RECT, pack_rect(320, 0, 1, 1, 16'h5555));
        send_item(rfs_pkg::REQ_RECT, pack_rect(0, 240, 1, 1, 16'hAAAA));
        send_item(rfs_pkg::REQ_RECT,
                  pack_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Top-left corner, two pixels of black.
        send_item(rfs_pkg::REQ_RECT, pack_rect(0, 0, 2, 1, 16'h0000));
        drain_transfer();
        settle();

        // A panel with no columns drops everything.
        apply_panel(0, 0, 239);
        send_item(rfs_pkg::REQ_RECT, pack_rect(0, 0, 1, 1, 16'h8001));
        send_item(rfs_pkg::REQ_ADVANCE, '0);
        settle();

        // Column count above the instance limit acts as the limit; the row
        // offset pushes the only usable row to the top address.
        apply_panel(2047, 1023, 1023);
        send_item(rfs_pkg::REQ_RECT, pack_rect(1024, 0, 1, 1, 16'h0F0F));
        send_item(rfs_pkg::REQ_RECT, pack_rect(1023, 0, 16'hFFFF, 16'hFFFF, 16'hA5A5));
        drain_transfer();
        settle();

        // Random part: a sweep of geometries, extremes first. Two of the
        // phases run with both sides idle-free.
        apply_panel(320, 0, 239);
        run_phase(190);
        apply_panel(1, 0, 0);
        run_phase(190);
        apply_panel(2047, 1023, 1023);
        run_phase(190);
        calm = 1'b1;
        apply_panel(1024, 0, 1023);
        run_phase(190);
        apply_panel(0, 512, 700);
        run_phase(190);
        calm = 1'b0;
        apply_panel(40, 900, 100);
        run_phase(190);
        repeat (4) begin
            ro = $urandom_range(1023, 0);
            apply_panel($urandom_range(2047, 1), ro, $urandom_range(1023, ro));
            run_phase(190);
        end

        $display("Drew %0d rectangles, dropped %0d and ignored %0d mid-transfer requests,",
                 sb.rects_drawn, sb.rects_dropped, sb.rects_ignored);
        $display("checking %0d display bytes across %0d panel geometries.",
                 sb.bytes_checked, settings_used);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rfs_pkg.sv
hw/rtl/rfs_clip.sv
hw/rtl/clipped_rectangle_fill_stream_unit.sv
hw/rtl/rfs_checker.sv
tb/tb_top.sv
